>>> hdl/etb_pkg.sv
// Shared types and codes for the elapsed timer bank.
package etb_pkg;

	// Command codes carried in the func field.
	localparam logic [2:0] FN_TICK       = 3'd0;
	localparam logic [2:0] FN_READ_FREE  = 3'd1;
	localparam logic [2:0] FN_CLEAR_FREE = 3'd2;
	localparam logic [2:0] FN_READ_WATCH = 3'd3;
	localparam logic [2:0] FN_STOP       = 3'd4;
	localparam logic [2:0] FN_START      = 3'd5;
	localparam logic [2:0] FN_PAUSE      = 3'd6;
	localparam logic [2:0] FN_CONTINUE   = 3'd7;

	// Stopwatch states.
	localparam logic [1:0] WS_STOPPED = 2'd0;
	localparam logic [1:0] WS_RUNNING = 2'd1;
	localparam logic [1:0] WS_PAUSED  = 2'd2;

	localparam int COUNT_W = 16;

	typedef struct packed {
		logic [2:0] func;
		logic [2:0] timer_index;
		logic [7:0] tick_count;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count_value;
		logic [1:0]         watch_state;
		logic               index_error;
	} rsp_t;

endpackage

>>> hdl/etb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module etb_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/elapsed_timer_bank_core.sv
// Elapsed timer bank: NUM_FREE free-running 16-bit counters and NUM_WATCH 16-bit
// stopwatches, each held in a small synchronous RAM (the stopwatch RAM keeps the
// count and the two-bit state side by side), with one valid flop per entry so that
// every counter reads as zero and every stopwatch as stopped right after reset,
// with no clearing pass. The block takes one command beat at a time. A command
// addressed to one entry does a read, a modify and a write-back before the next
// beat can be accepted, and waits in the output state while the response register
// is full; a command whose index is beyond its bank skips the RAMs. A tick sweeps
// both RAMs entry by entry (read, then modify and write back) over
// max(NUM_FREE, NUM_WATCH) entries; that sweep over the single RAM port pair is
// what sets the tick rate. Each command yields exactly one response beat, held in
// an output register, so a new command is taken while the previous response still
// waits for the consumer.
module elapsed_timer_bank_core
	import etb_pkg::*;
#(
	parameter int NUM_FREE  = 8,
	parameter int NUM_WATCH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Sweep length and address widths follow from the bank sizes.
	localparam int NUM_MAX = (NUM_FREE > NUM_WATCH) ? NUM_FREE : NUM_WATCH;
	localparam int MAX_AW  = (NUM_MAX > 1) ? $clog2(NUM_MAX) : 1;
	localparam int PTR_W   = (MAX_AW > 3) ? MAX_AW : 3;
	localparam int FA_W    = (NUM_FREE > 1) ? $clog2(NUM_FREE) : 1;
	localparam int WA_W    = (NUM_WATCH > 1) ? $clog2(NUM_WATCH) : 1;
	localparam int WW      = COUNT_W + 2;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]       state_q;
	logic [PTR_W-1:0] ptr_q;
	logic [2:0]       func_q;
	logic [7:0]       ticks_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [NUM_FREE-1:0]  fvld_q;
	logic [NUM_WATCH-1:0] wvld_q;

	logic [FA_W-1:0]    fa;
	logic [WA_W-1:0]    wa;
	logic               f_in_range;
	logic               w_in_range;
	logic               last_entry;
	logic               accept;
	logic               req_err;
	logic               out_load;

	logic               f_re;
	logic               f_we;
	logic [COUNT_W-1:0] f_wdata;
	logic [COUNT_W-1:0] f_rdata;
	logic               w_re;
	logic               w_we;
	logic [WW-1:0]      w_wdata;
	logic [WW-1:0]      w_rdata;

	logic [COUNT_W-1:0] free_old;
	logic [COUNT_W-1:0] watch_cnt_old;
	logic [1:0]         watch_st_old;
	logic [COUNT_W-1:0] watch_cnt_new;
	logic [1:0]         watch_st_new;
	rsp_t               res_new;

	assign fa         = ptr_q[FA_W-1:0];
	assign wa         = ptr_q[WA_W-1:0];
	assign f_in_range = 32'(ptr_q) < 32'(NUM_FREE);
	assign w_in_range = 32'(ptr_q) < 32'(NUM_WATCH);
	assign last_entry = ptr_q == PTR_W'(NUM_MAX - 1);

	assign req_ready = state_q == ST_IDLE;
	assign accept    = req_valid && req_ready;

	// The free bank bounds the free-counter commands, the stopwatch bank the rest but the tick, which has no index check.
	always_comb begin
		req_err = 1'b0;
		if (req.func == FN_READ_FREE || req.func == FN_CLEAR_FREE) begin
			req_err = 32'(req.timer_index) >= 32'(NUM_FREE);
		end else if (req.func != FN_TICK) begin
			req_err = 32'(req.timer_index) >= 32'(NUM_WATCH);
		end
	end

	// Entries never written since reset read as zero, which is also the stopped state.
	assign free_old      = (f_in_range && fvld_q[fa]) ? f_rdata : '0;
	assign watch_cnt_old = (w_in_range && wvld_q[wa]) ? w_rdata[COUNT_W-1:0] : '0;
	assign watch_st_old  = (w_in_range && wvld_q[wa]) ? w_rdata[WW-1:COUNT_W] : WS_STOPPED;

	// Modify step of the read-modify-write, one entry of each bank per pass.
	always_comb begin
		watch_cnt_new = watch_cnt_old;
		watch_st_new  = watch_st_old;
		f_wdata       = free_old;
		f_we          = 1'b0;
		w_we          = 1'b0;
		res_new       = '0;
		if (state_q == ST_WR) begin
			unique case (func_q)
				FN_TICK: begin
					f_wdata = free_old + COUNT_W'(ticks_q);
					f_we    = f_in_range;
					if (watch_st_old == WS_RUNNING) begin
						watch_cnt_new = watch_cnt_old + COUNT_W'(ticks_q);
					end
					w_we = w_in_range;
				end
				FN_READ_FREE: begin
					res_new.count_value = free_old;
				end
				FN_CLEAR_FREE: begin
					f_wdata = '0;
					f_we    = 1'b1;
				end
				FN_READ_WATCH: begin
					res_new.count_value = watch_cnt_old;
				end
				FN_STOP: begin
					watch_st_new = WS_STOPPED;
					w_we         = 1'b1;
				end
				FN_START: begin
					if (watch_st_old == WS_STOPPED) begin
						watch_cnt_new = '0;
						watch_st_new  = WS_RUNNING;
					end
					w_we = 1'b1;
				end
				FN_PAUSE: begin
					if (watch_st_old == WS_RUNNING) begin
						watch_st_new = WS_PAUSED;
					end
					w_we = 1'b1;
				end
				FN_CONTINUE: begin
					if (watch_st_old == WS_PAUSED) begin
						watch_st_new = WS_RUNNING;
					end
					w_we = 1'b1;
				end
				default: begin
				end
			endcase
			if (func_q != FN_TICK && func_q != FN_READ_FREE && func_q != FN_CLEAR_FREE) begin
				res_new.watch_state = watch_st_new;
			end
		end
	end

	assign w_wdata = {watch_st_new, watch_cnt_new};
	assign f_re    = (state_q == ST_RD) && f_in_range;
	assign w_re    = (state_q == ST_RD) && w_in_range;

	etb_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (NUM_FREE)
	) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (fa),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (fa),
		.rdata (f_rdata)
	);

	etb_ram #(
		.WIDTH (WW),
		.DEPTH (NUM_WATCH)
	) u_watch_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (wa),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (wa),
		.rdata (w_rdata)
	);

	// The response register takes a new beat when it is empty or being emptied.
	assign out_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			fvld_q      <= '0;
			wvld_q      <= '0;
		end else begin
			if (f_we) begin
				fvld_q[fa] <= 1'b1;
			end
			if (w_we) begin
				wvld_q[wa] <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= req_err ? ST_OUT : ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= (func_q == FN_TICK && !last_entry) ? ST_RD : ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command fields, sweep pointer and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			ticks_q <= req.tick_count;
			ptr_q   <= (req.func == FN_TICK) ? '0 : PTR_W'(req.timer_index);
			res_q   <= '{count_value: '0, watch_state: WS_STOPPED, index_error: req_err};
		end else if (state_q == ST_WR) begin
			ptr_q <= ptr_q + PTR_W'(1);
			res_q <= res_new;
		end
		if (out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// The RAMs are written only in the modify step of the sequencer.
	a_write_in_modify: assert property (@(posedge clk) disable iff (!arst_n)
		(f_we || w_we) |-> state_q == ST_WR)
		else $error("RAM write outside the modify step");

	// A stopwatch is never stored with the unused state code.
	a_watch_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		w_we |-> w_wdata[WW-1:COUNT_W] != 2'd3)
		else $error("stopwatch written with an undefined state");

	// A tick always answers with an all-zero response.
	a_tick_response: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && func_q == FN_TICK) |-> res_q == '0)
		else $error("tick response is not zero");

	// An accepted command always leaves the idle state.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted command did not start");
`endif

endmodule
